// ===== hdl/rhc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and constants for the pipelined RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

	// default fraction bits of hue (degrees) and saturation
	localparam int unsigned HUE_FRAC_BITS_DEF = 7;
	localparam int unsigned SAT_FRAC_BITS_DEF = 15;

	// hue quotient <= 120 * 2^F needs F+7 bits, saturation quotient <= 2^S needs S+1
	localparam int unsigned HUE_Q_EXTRA = 7;
	localparam int unsigned SAT_Q_EXTRA = 1;

	// divisors are 2*diff or 2*max, both at most 510
	localparam int unsigned DVS_W = 9;

	localparam int unsigned CH_W = 8;

	// 2 * 60 degrees, scale of the rounded sector fraction
	localparam int unsigned HUE_SCALE = 120;
	localparam int unsigned DEG_FULL  = 360;

	// sector base in degrees after folding the lower sector edge into the quotient,
	// taken modulo 360
	localparam int unsigned BASE_RED   = 300;
	localparam int unsigned BASE_GREEN = 60;
	localparam int unsigned BASE_BLUE  = 180;

	typedef enum logic [1:0] {
		SEC_RED   = 2'd0,
		SEC_GREEN = 2'd1,
		SEC_BLUE  = 2'd2
	} sector_t;

	// sideband that travels with each item through the divider
	typedef struct packed {
		sector_t          sector;
		logic             gray;
		logic             black;
		logic [CH_W-1:0]  mx;
	} side_t;

endpackage
`default_nettype wire

// ===== hdl/rhc_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_front
// Three stages: max/min and sector, difference and sector delta, divider
// numerators and divisors.
// ----------------------------------------------------------------------------
module rhc_front import rhc_pkg::*; #(
	parameter int unsigned HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter int unsigned SAT_FRAC_BITS = SAT_FRAC_BITS_DEF,
	parameter int unsigned STEPS         = HUE_FRAC_BITS_DEF + HUE_Q_EXTRA
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [CH_W-1:0]          red,
	input  wire logic [CH_W-1:0]          green,
	input  wire logic [CH_W-1:0]          blue,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output side_t                         out_side,
	output logic [STEPS+DVS_W-1:0]        out_dvd_h,
	output logic [DVS_W-1:0]              out_dvs_h,
	output logic [STEPS+DVS_W-1:0]        out_dvd_s,
	output logic [DVS_W-1:0]              out_dvs_s
);

	localparam int unsigned DVD_W = STEPS + DVS_W;
	localparam logic [DVD_W-1:0] HUE_MUL = DVD_W'(HUE_SCALE) << HUE_FRAC_BITS;

	logic en1, en2, en3;

	// stage 1
	logic            vld_s1;
	logic [CH_W-1:0] r_s1, g_s1, b_s1, mx_s1, mn_s1;
	sector_t         sec_s1;

	// stage 2
	logic            vld_s2;
	logic [CH_W-1:0] d_s2, mx_s2;
	logic [DVS_W-1:0] dlt_s2;
	sector_t         sec_s2;

	// stage 3
	logic             vld_s3;
	side_t            side_s3;
	logic [DVD_W-1:0] dvd_h_s3, dvd_s_s3;
	logic [DVS_W-1:0] dvs_h_s3, dvs_s_s3;

	logic [CH_W-1:0] mx_c, mn_c, pos_c, neg_c, d_c;
	sector_t         sec_c;
	logic [DVS_W:0]  dlt_c;

	assign en3      = !vld_s3 || out_ready;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_ready = en1;

	always_comb begin
		mx_c = (red > green) ? red : green;
		mx_c = (blue > mx_c) ? blue : mx_c;
		mn_c = (red < green) ? red : green;
		mn_c = (blue < mn_c) ? blue : mn_c;
		// ties: blue over green over red
		if (blue >= red && blue >= green) begin
			sec_c = SEC_BLUE;
		end else if (green >= red) begin
			sec_c = SEC_GREEN;
		end else begin
			sec_c = SEC_RED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			r_s1   <= red;
			g_s1   <= green;
			b_s1   <= blue;
			mx_s1  <= mx_c;
			mn_s1  <= mn_c;
			sec_s1 <= sec_c;
		end
	end

	// sector delta shifted by +d so it stays in [0, 2d]
	always_comb begin
		unique case (sec_s1)
			SEC_RED: begin
				pos_c = g_s1;
				neg_c = b_s1;
			end
			SEC_GREEN: begin
				pos_c = b_s1;
				neg_c = r_s1;
			end
			SEC_BLUE: begin
				pos_c = r_s1;
				neg_c = g_s1;
			end
			default: begin
				pos_c = g_s1;
				neg_c = b_s1;
			end
		endcase
		d_c   = mx_s1 - mn_s1;
		dlt_c = (DVS_W+1)'(pos_c) + (DVS_W+1)'(d_c) - (DVS_W+1)'(neg_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			d_s2   <= d_c;
			mx_s2  <= mx_s1;
			dlt_s2 <= dlt_c[DVS_W-1:0];
			sec_s2 <= sec_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en3) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			side_s3.sector <= sec_s2;
			side_s3.gray   <= (d_s2 == '0);
			side_s3.black  <= (mx_s2 == '0);
			side_s3.mx     <= mx_s2;
			dvd_h_s3       <= DVD_W'(dlt_s2) * HUE_MUL + DVD_W'(d_s2);
			dvs_h_s3       <= {d_s2, 1'b0};
			dvd_s_s3       <= (DVD_W'(d_s2) << (SAT_FRAC_BITS + 1)) + DVD_W'(mx_s2);
			dvs_s_s3       <= {mx_s2, 1'b0};
		end
	end

	assign out_valid = vld_s3;
	assign out_side  = side_s3;
	assign out_dvd_h = dvd_h_s3;
	assign out_dvs_h = dvs_h_s3;
	assign out_dvd_s = dvd_s_s3;
	assign out_dvs_s = dvs_s_s3;

endmodule
`default_nettype wire

// ===== hdl/rhc_div_pipe.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Dividend top bits must be below the divisor.
// ----------------------------------------------------------------------------
module rhc_div_pipe import rhc_pkg::*; #(
	parameter int unsigned STEPS = HUE_FRAC_BITS_DEF + HUE_Q_EXTRA
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire side_t                    in_side,
	input  wire logic [STEPS+DVS_W-1:0]   in_dvd_h,
	input  wire logic [DVS_W-1:0]         in_dvs_h,
	input  wire logic [STEPS+DVS_W-1:0]   in_dvd_s,
	input  wire logic [DVS_W-1:0]         in_dvs_s,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output side_t                         out_side,
	output logic [STEPS-1:0]              out_quo_h,
	output logic [STEPS-1:0]              out_quo_s
);

	localparam int unsigned DVD_W = STEPS + DVS_W;
	localparam int unsigned LANES = 2;

	logic [STEPS:1]   vld_s;
	logic [STEPS+1:1] adv;
	side_t            side_s [1:STEPS];

	logic [DVS_W-1:0] rem_s [LANES][1:STEPS];
	logic [STEPS-1:0] acc_s [LANES][1:STEPS];
	logic [DVS_W-1:0] dvs_s [LANES][1:STEPS];

	// values feeding each step: index 0 is the input
	logic [DVS_W-1:0] cur_rem [LANES][0:STEPS-1];
	logic [STEPS-1:0] cur_acc [LANES][0:STEPS-1];
	logic [DVS_W-1:0] cur_dvs [LANES][0:STEPS-1];
	side_t            cur_side [0:STEPS-1];
	logic [STEPS-1:0] cur_vld;

	logic [DVD_W-1:0] dvd_in [LANES];
	logic [DVS_W-1:0] dvs_in [LANES];

	assign dvd_in[0] = in_dvd_h;
	assign dvd_in[1] = in_dvd_s;
	assign dvs_in[0] = in_dvs_h;
	assign dvs_in[1] = in_dvs_s;

	assign adv[STEPS+1] = out_ready;
	assign cur_vld[0]   = in_valid;
	assign cur_side[0]  = in_side;
	assign in_ready     = adv[1];

	genvar k, ln;
	generate
		for (ln = 0; ln < LANES; ln++) begin : g_lane_in
			assign cur_rem[ln][0] = dvd_in[ln][DVD_W-1:STEPS];
			assign cur_acc[ln][0] = dvd_in[ln][STEPS-1:0];
			assign cur_dvs[ln][0] = dvs_in[ln];
		end

		for (k = 1; k <= STEPS; k++) begin : g_stage
			assign adv[k] = !vld_s[k] || adv[k+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (adv[k]) begin
					vld_s[k] <= cur_vld[k-1];
				end
			end

			always_ff @(posedge clk) begin
				if (adv[k]) begin
					side_s[k] <= cur_side[k-1];
				end
			end

			if (k < STEPS) begin : g_fwd
				assign cur_vld[k]  = vld_s[k];
				assign cur_side[k] = side_s[k];
			end

			for (ln = 0; ln < LANES; ln++) begin : g_lane
				logic [DVS_W:0]   trial;
				logic             ge;
				logic [DVS_W:0]   diff;

				// shift in the next dividend bit, subtract when it fits
				assign trial = {cur_rem[ln][k-1], cur_acc[ln][k-1][STEPS-1]};
				assign ge    = (trial >= {1'b0, cur_dvs[ln][k-1]});
				assign diff  = trial - {1'b0, cur_dvs[ln][k-1]};

				always_ff @(posedge clk) begin
					if (adv[k]) begin
						rem_s[ln][k] <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
						acc_s[ln][k] <= {cur_acc[ln][k-1][STEPS-2:0], ge};
						dvs_s[ln][k] <= cur_dvs[ln][k-1];
					end
				end

				if (k < STEPS) begin : g_fwd
					assign cur_rem[ln][k] = rem_s[ln][k];
					assign cur_acc[ln][k] = acc_s[ln][k];
					assign cur_dvs[ln][k] = dvs_s[ln][k];
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[STEPS];
	assign out_side  = side_s[STEPS];
	assign out_quo_h = acc_s[0][STEPS];
	assign out_quo_s = acc_s[1][STEPS];

endmodule
`default_nettype wire

// ===== hdl/rhc_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_back
// Adds the sector base to the hue quotient, wraps at 360 degrees, applies
// the gray and black cases, and holds the result in the output register.
// ----------------------------------------------------------------------------
module rhc_back import rhc_pkg::*; #(
	parameter int unsigned HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter int unsigned STEPS         = HUE_FRAC_BITS_DEF + HUE_Q_EXTRA
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire side_t             in_side,
	input  wire logic [STEPS-1:0]  in_quo_h,
	input  wire logic [STEPS-1:0]  in_quo_s,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [15:0]            hue,
	output logic [15:0]            saturation,
	output logic [CH_W-1:0]        brightness
);

	localparam int unsigned HA_W = (HUE_FRAC_BITS + 9 > STEPS) ? HUE_FRAC_BITS + 9 : STEPS;
	localparam int unsigned HW   = (HA_W > 16) ? HA_W : 16;
	localparam int unsigned SW   = (STEPS > 16) ? STEPS : 16;
	localparam logic [HW-1:0] FULL = HW'(DEG_FULL) << HUE_FRAC_BITS;

	logic          en1;
	logic          vld_s1;
	logic [15:0]   hue_s1, sat_s1;
	logic [CH_W-1:0] bri_s1;

	logic [HW-1:0] base_c, sum_c, hue_c;
	logic [SW-1:0] sat_c;

	assign en1      = !vld_s1 || out_ready;
	assign in_ready = en1;

	always_comb begin
		unique case (in_side.sector)
			SEC_RED:   base_c = HW'(BASE_RED) << HUE_FRAC_BITS;
			SEC_GREEN: base_c = HW'(BASE_GREEN) << HUE_FRAC_BITS;
			SEC_BLUE:  base_c = HW'(BASE_BLUE) << HUE_FRAC_BITS;
			default:   base_c = HW'(BASE_RED) << HUE_FRAC_BITS;
		endcase
		sum_c = base_c + HW'(in_quo_h);
		if (in_side.gray) begin
			hue_c = '0;
		end else if (sum_c >= FULL) begin
			hue_c = sum_c - FULL;
		end else begin
			hue_c = sum_c;
		end
		sat_c = in_side.black ? '0 : SW'(in_quo_s);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			hue_s1 <= hue_c[15:0];
			sat_s1 <= sat_c[15:0];
			bri_s1 <= in_side.mx;
		end
	end

	assign out_valid  = vld_s1;
	assign hue        = hue_s1;
	assign saturation = sat_s1;
	assign brightness = bri_s1;

endmodule
`default_nettype wire

// ===== hdl/rgb_to_hsv_converter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// Pipelined RGB to HSV conversion of 8-bit pixels.
//
// Channel  Handshake              Payload
// -------  ---------------------  ----------------------------------------
// pixel    pix_valid / pix_ready  red, green, blue (8 bits each)
// hsv      hsv_valid / hsv_ready  hue (deg, Q.HUE_FRAC_BITS), saturation
//                                 (Q1.SAT_FRAC_BITS), brightness (8 bits)
//
// One item per cycle sustained while hsv_ready stays high. Items pass through the
// front stages, then STEPS = max(HUE_FRAC_BITS + 7, SAT_FRAC_BITS + 1)
// restoring-divider stages, one quotient bit each, then the output register.
// Reset clears all valid bits; payload registers are not reset.
// A stall holds each full stage; empty stages still fill, so bubbles collapse.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top import rhc_pkg::*; #(
	parameter int unsigned HUE_FRAC_BITS = HUE_FRAC_BITS_DEF,
	parameter int unsigned SAT_FRAC_BITS = SAT_FRAC_BITS_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            pix_valid,
	output logic                 pix_ready,
	input  wire logic [CH_W-1:0] red,
	input  wire logic [CH_W-1:0] green,
	input  wire logic [CH_W-1:0] blue,
	output logic                 hsv_valid,
	input  wire logic            hsv_ready,
	output logic [15:0]          hue,
	output logic [15:0]          saturation,
	output logic [CH_W-1:0]      brightness
);

	localparam int unsigned HUE_Q_W = HUE_FRAC_BITS + HUE_Q_EXTRA;
	localparam int unsigned SAT_Q_W = SAT_FRAC_BITS + SAT_Q_EXTRA;
	localparam int unsigned STEPS   = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;
	localparam int unsigned DVD_W   = STEPS + DVS_W;

	logic             f_valid, f_ready;
	side_t            f_side;
	logic [DVD_W-1:0] f_dvd_h, f_dvd_s;
	logic [DVS_W-1:0] f_dvs_h, f_dvs_s;

	logic             d_valid, d_ready;
	side_t            d_side;
	logic [STEPS-1:0] d_quo_h, d_quo_s;

	rhc_front #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.SAT_FRAC_BITS (SAT_FRAC_BITS),
		.STEPS         (STEPS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_valid),
		.in_ready  (pix_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_side  (f_side),
		.out_dvd_h (f_dvd_h),
		.out_dvs_h (f_dvs_h),
		.out_dvd_s (f_dvd_s),
		.out_dvs_s (f_dvs_s)
	);

	rhc_div_pipe #(
		.STEPS (STEPS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_side   (f_side),
		.in_dvd_h  (f_dvd_h),
		.in_dvs_h  (f_dvs_h),
		.in_dvd_s  (f_dvd_s),
		.in_dvs_s  (f_dvs_s),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_side  (d_side),
		.out_quo_h (d_quo_h),
		.out_quo_s (d_quo_s)
	);

	rhc_back #(
		.HUE_FRAC_BITS (HUE_FRAC_BITS),
		.STEPS         (STEPS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (d_valid),
		.in_ready   (d_ready),
		.in_side    (d_side),
		.in_quo_h   (d_quo_h),
		.in_quo_s   (d_quo_s),
		.out_valid  (hsv_valid),
		.out_ready  (hsv_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule
`default_nettype wire
